// ===== design/crcfp_pkg.sv =====
// Shared constants, types and the byte-wise CRC-16 update for the frame parser.
package crcfp_pkg;

    // Largest payload length a frame may declare; longer frames are discarded.
    localparam int MAX_PAYLOAD = 256;

    // Width of the length and payload position registers: enough for MAX_PAYLOAD,
    // and never less than the 9-bit length field of the result.
    localparam int LEN_W = ($clog2(MAX_PAYLOAD + 1) > 9) ? $clog2(MAX_PAYLOAD + 1) : 9;

    // Payload store geometry.
    localparam int STORE_DEPTH = 256;
    localparam int STORE_AW    = 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  SOF_RESET = 8'hAA;

    // Input and result packing.
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 40;

    typedef struct packed {
        logic       ok;
        logic [7:0] seq;
        logic [7:0] command;
        logic [8:0] length;
    } parse_res_t;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } store_wr_t;

    // CRC-16, polynomial 0x1021, MSB first, one byte per call.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/crcfp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module crcfp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/crcfp_parser.sv =====
// Frame parsing state machine with the running CRC and the header registers.
module crcfp_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [7:0]            cfg_data,
    input  logic                  feed,
    input  logic [7:0]            rx_byte,
    output crcfp_pkg::parse_res_t res,
    output crcfp_pkg::store_wr_t  store_wr
);

    localparam logic [2:0] PH_SOF  = 3'd0;
    localparam logic [2:0] PH_SEQ  = 3'd1;
    localparam logic [2:0] PH_CMD  = 3'd2;
    localparam logic [2:0] PH_LENL = 3'd3;
    localparam logic [2:0] PH_LENH = 3'd4;
    localparam logic [2:0] PH_DATA = 3'd5;
    localparam logic [2:0] PH_CRCH = 3'd6;
    localparam logic [2:0] PH_CRCL = 3'd7;

    localparam int LW = crcfp_pkg::LEN_W;

    logic [2:0]    phase_reg,   phase_next;
    logic [7:0]    seq_reg,     seq_next;
    logic [7:0]    command_reg, command_next;
    logic [LW-1:0] len_reg,     len_next;
    logic [LW-1:0] idx_reg,     idx_next;
    logic [7:0]    crc_hi_reg,  crc_hi_next;
    logic [15:0]   crc_reg,     crc_next;
    logic [7:0]    sof_reg;

    logic [15:0]   crc_upd;
    logic [15:0]   len_full;
    logic [LW-1:0] idx_inc;
    logic          ok;

    assign crc_upd  = crcfp_pkg::crc_byte(crc_reg, rx_byte);
    assign len_full = {rx_byte, len_reg[7:0]};
    assign idx_inc  = idx_reg + LW'(1);

    always_comb begin
        phase_next   = phase_reg;
        seq_next     = seq_reg;
        command_next = command_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        crc_hi_next  = crc_hi_reg;
        crc_next     = crc_reg;
        ok           = 1'b0;
        store_wr.en   = 1'b0;
        store_wr.addr = idx_reg[crcfp_pkg::STORE_AW-1:0];
        store_wr.data = rx_byte;
        if (feed) begin
            case (phase_reg)
                PH_SOF: begin
                    if (rx_byte == sof_reg) begin
                        crc_next   = crcfp_pkg::CRC_INIT;
                        phase_next = PH_SEQ;
                    end
                end
                PH_SEQ: begin
                    seq_next   = rx_byte;
                    crc_next   = crc_upd;
                    phase_next = PH_CMD;
                end
                PH_CMD: begin
                    command_next = rx_byte;
                    crc_next     = crc_upd;
                    phase_next   = PH_LENL;
                end
                PH_LENL: begin
                    len_next   = LW'(rx_byte);
                    crc_next   = crc_upd;
                    phase_next = PH_LENH;
                end
                PH_LENH: begin
                    crc_next = crc_upd;
                    idx_next = '0;
                    if ({1'b0, len_full} > 17'(crcfp_pkg::MAX_PAYLOAD)) begin
                        len_next   = '0;
                        phase_next = PH_SOF;
                    end else begin
                        len_next   = LW'(len_full);
                        phase_next = (len_full == 16'd0) ? PH_CRCH : PH_DATA;
                    end
                end
                PH_DATA: begin
                    // Positions beyond the store are counted but not kept.
                    store_wr.en = (idx_reg[LW-1:crcfp_pkg::STORE_AW] == '0);
                    crc_next    = crc_upd;
                    idx_next    = idx_inc;
                    if (idx_inc >= len_reg) begin
                        phase_next = PH_CRCH;
                    end
                end
                PH_CRCH: begin
                    crc_hi_next = rx_byte;
                    phase_next  = PH_CRCL;
                end
                default: begin
                    phase_next = PH_SOF;
                    ok         = ({crc_hi_reg, rx_byte} == crc_reg);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SOF;
            seq_reg     <= '0;
            command_reg <= '0;
            len_reg     <= '0;
            idx_reg     <= '0;
            crc_hi_reg  <= '0;
            crc_reg     <= crcfp_pkg::CRC_INIT;
            sof_reg     <= crcfp_pkg::SOF_RESET;
        end else begin
            phase_reg   <= phase_next;
            seq_reg     <= seq_next;
            command_reg <= command_next;
            len_reg     <= len_next;
            idx_reg     <= idx_next;
            crc_hi_reg  <= crc_hi_next;
            crc_reg     <= crc_next;
            if (cfg_valid) begin
                sof_reg <= cfg_data;
            end
        end
    end

    assign res.ok      = ok;
    assign res.seq     = seq_next;
    assign res.command = command_next;
    assign res.length  = len_next[8:0];

endmodule

// ===== design/crc16_frame_parser.sv =====
// Top level of the CRC-16 frame parser: handshakes, payload store and result stages.
//
// The block takes one transaction per clock and returns exactly one result per
// transaction, passing it through a stage register and then the result register.
// A feed transaction (s_tuser = 0) advances the frame parser by one received byte
// and updates the CRC-16 in the same cycle; a read transaction (s_tuser = 1) reads
// the payload store, whose registered read port feeds the result register. The
// payload store is a 256-byte RAM written during the payload phase and needs no
// clearing after reset. A result register and a stage ahead of it decouple the two
// sides, so input is taken at full rate while m_tready is high. The start-of-frame
// byte is set through the cfg_valid/cfg_data channel, which is always ready.
module crc16_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte [7:0], read_index [15:8]
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // frame_ok [0], frame_seq [8:1], frame_command [16:9],
                                   // frame_length [25:17], read_data [33:26], zeros above
);

    crcfp_pkg::parse_res_t res;
    crcfp_pkg::store_wr_t  store_wr;

    logic       accept;
    logic       feed;
    logic       rd_en;
    logic [7:0] rd_data;
    logic       p1_adv;

    logic                  p1_valid_reg, p1_valid_next;
    crcfp_pkg::parse_res_t p1_res_reg;
    logic                  p1_read_reg;
    logic                  m_valid_reg,  m_valid_next;
    logic [39:0]           m_data_reg;

    assign p1_adv    = !m_valid_reg || m_tready;
    assign s_tready  = !p1_valid_reg || p1_adv;
    assign accept    = s_tvalid && s_tready;
    assign feed      = accept && !s_tuser;
    assign rd_en     = accept && s_tuser;
    assign cfg_ready = 1'b1;

    crcfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .feed      (feed),
        .rx_byte   (s_tdata[7:0]),
        .res       (res),
        .store_wr  (store_wr)
    );

    crcfp_ram #(
        .WIDTH (8),
        .DEPTH (crcfp_pkg::STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_wr.en),
        .wr_addr (store_wr.addr),
        .wr_data (store_wr.data),
        .rd_en   (rd_en),
        .rd_addr (s_tdata[15:8]),
        .rd_data (rd_data)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (accept) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (p1_adv && p1_valid_reg) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // The RAM output holds while the stage is stalled, since no new read is issued then.
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_res_reg  <= res;
            p1_read_reg <= s_tuser;
        end
        if (p1_adv && p1_valid_reg) begin
            m_data_reg <= {6'd0,
                           p1_read_reg ? rd_data : 8'd0,
                           p1_res_reg.length,
                           p1_res_reg.command,
                           p1_res_reg.seq,
                           p1_res_reg.ok};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== dv/crc16_frame_parser_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the CRC-16 frame parser: directed table, then random frames.
module crc16_frame_parser_tb;

    typedef enum bit {OP_FEED = 1'b0, OP_READ = 1'b1} op_t;

    typedef enum logic [2:0] {
        HUNT, GET_SEQ, GET_CMD, GET_LEN_LO, GET_LEN_HI, GET_PAYLOAD, GET_CRC_HI, GET_CRC_LO
    } parse_phase_t;

    // Directed rows either carry a literal byte or take the CRC bytes of the open frame.
    typedef enum logic [2:0] {ROW_FEED, ROW_READ, ROW_CRC_HI, ROW_CRC_LO, ROW_CRC_BAD} row_kind_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] seq;
        logic [7:0] command;
        logic [8:0] length;
        logic [7:0] rdata;
    } frame_result_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [7:0]    data;
        logic [7:0]    index;
        logic          typed;
        frame_result_t res;
    } dir_row_t;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_GEN  = 16'h1021;
    localparam int          IDLE_PCT = 8;
    localparam int          PHASE_ITEMS = 405;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;   // rx_byte [7:0], read_index [15:8]
    logic        s_tuser = 1'b0;       // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;              // frame_ok [0], frame_seq [8:1], frame_command [16:9],
                                       // frame_length [25:17], read_data [33:26], zeros above

    crc16_frame_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Shadow copy of the parser state.
    logic [7:0]    sof_cur = crcfp_pkg::SOF_RESET;
    parse_phase_t  ph = HUNT;
    logic [7:0]    seq_q = 8'h00;
    logic [7:0]    cmd_q = 8'h00;
    logic [15:0]   len_q = 16'h0000;
    int unsigned   pos_q = 0;
    logic [15:0]   rx_crc = 16'h0000;
    logic [15:0]   crc_acc = CRC_SEED;
    logic [7:0]    store_mem [256];
    bit            stored [256];
    logic [7:0]    stored_list [$];

    frame_result_t pending_results [$];
    frame_result_t typed_res;
    bit            typed_valid = 1'b0;
    bit            calm = 1'b0;
    int unsigned   items_sent = 0;
    int            err_count = 0;
    dir_row_t      dir_rows [25];

    // Bit-serial form of the 0x1021 CRC, MSB of the byte first.
    function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_GEN;
            end
        end
        return crc;
    endfunction

    function automatic frame_result_t parser_step(op_t op, logic [7:0] b, logic [7:0] ri);
        frame_result_t r;
        r = '0;
        if (op == OP_READ) begin
            r.rdata = store_mem[ri];
        end else begin
            case (ph)
                HUNT: begin
                    if (b == sof_cur) begin
                        crc_acc = CRC_SEED;
                        ph = GET_SEQ;
                    end
                end
                GET_SEQ: begin
                    seq_q = b;
                    crc_acc = crc16_update(crc_acc, b);
                    ph = GET_CMD;
                end
                GET_CMD: begin
                    cmd_q = b;
                    crc_acc = crc16_update(crc_acc, b);
                    ph = GET_LEN_LO;
                end
                GET_LEN_LO: begin
                    len_q = {8'h00, b};
                    crc_acc = crc16_update(crc_acc, b);
                    ph = GET_LEN_HI;
                end
                GET_LEN_HI: begin
                    len_q[15:8] = b;
                    crc_acc = crc16_update(crc_acc, b);
                    pos_q = 0;
                    if (len_q > crcfp_pkg::MAX_PAYLOAD) begin
                        len_q = 16'h0000;
                        ph = HUNT;
                    end else begin
                        ph = (len_q != 0) ? GET_PAYLOAD : GET_CRC_HI;
                    end
                end
                GET_PAYLOAD: begin
                    if (pos_q < 256) begin
                        store_mem[pos_q] = b;
                        if (!stored[pos_q]) begin
                            stored[pos_q] = 1'b1;
                            stored_list.push_back(8'(pos_q));
                        end
                    end
                    crc_acc = crc16_update(crc_acc, b);
                    pos_q++;
                    if (pos_q >= len_q) begin
                        ph = GET_CRC_HI;
                    end
                end
                GET_CRC_HI: begin
                    rx_crc = {b, 8'h00};
                    ph = GET_CRC_LO;
                end
                GET_CRC_LO: begin
                    rx_crc[7:0] = b;
                    ph = HUNT;
                    r.ok = (rx_crc == crc_acc);
                end
                default: ph = HUNT;
            endcase
        end
        r.seq = seq_q;
        r.command = cmd_q;
        r.length = len_q[8:0];
        return r;
    endfunction

    // Prediction on the input side, comparison on the result side. Pushing before
    // popping keeps this correct for any latency.
    always @(posedge aclk) begin
        frame_result_t want;
        frame_result_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sof_cur = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                want = parser_step(op_t'(s_tuser), s_tdata[7:0], s_tdata[15:8]);
                if (typed_valid) begin
                    want = typed_res;
                end
                pending_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[8:1], m_tdata[16:9], m_tdata[25:17], m_tdata[33:26]};
                if (pending_results.size() == 0) begin
                    err_count++;
                    $error("result transaction with nothing expected: m_tdata %h", m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    if (got.ok !== want.ok) begin
                        err_count++;
                        $error("frame_ok: expected %0d, actual %0d", want.ok, got.ok);
                    end
                    if (got.seq !== want.seq) begin
                        err_count++;
                        $error("frame_seq: expected %h, actual %h", want.seq, got.seq);
                    end
                    if (got.command !== want.command) begin
                        err_count++;
                        $error("frame_command: expected %h, actual %h", want.command, got.command);
                    end
                    if (got.length !== want.length) begin
                        err_count++;
                        $error("frame_length: expected %0d, actual %0d", want.length, got.length);
                    end
                    if (got.rdata !== want.rdata) begin
                        err_count++;
                        $error("read_data: expected %h, actual %h", want.rdata, got.rdata);
                    end
                    if (m_tdata[39:34] !== 6'b0) begin
                        err_count++;
                        $error("m_tdata padding: expected %h, actual %h", 6'b0, m_tdata[39:34]);
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(op_t op, logic [7:0] rx, logic [7:0] ri);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {ri, rx};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        typed_valid = 1'b0;
        items_sent++;
    endtask

    // Reads only ever target payload positions that have been written.
    task automatic feed_byte(logic [7:0] b);
        if (stored_list.size() != 0 && $urandom_range(0, 99) < 6) begin
            send_item(OP_READ, 8'($urandom_range(0, 255)),
                      stored_list[$urandom_range(0, stored_list.size() - 1)]);
        end
        send_item(OP_FEED, b, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_frame(logic [15:0] len, bit corrupt);
        logic [15:0] crc;
        logic [7:0]  hdr [4];
        logic [7:0]  b;
        crc = CRC_SEED;
        hdr[0] = 8'($urandom_range(0, 255));
        hdr[1] = 8'($urandom_range(0, 255));
        hdr[2] = len[7:0];
        hdr[3] = len[15:8];
        feed_byte(sof_cur);
        for (int i = 0; i < 4; i++) begin
            crc = crc16_update(crc, hdr[i]);
            feed_byte(hdr[i]);
        end
        if (len > crcfp_pkg::MAX_PAYLOAD) begin
            return;
        end
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            crc = crc16_update(crc, b);
            feed_byte(b);
        end
        if (corrupt) begin
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        end
        feed_byte(crc[15:8]);
        feed_byte(crc[7:0]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_sof(logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int unsigned budget, bit with_full);
        int unsigned first;
        int unsigned pick;
        logic [15:0] len;
        first = items_sent;
        if (with_full) begin
            send_frame(16'(crcfp_pkg::MAX_PAYLOAD), 1'b0);
        end
        while (items_sent - first < budget) begin
            repeat ($urandom_range(0, 2)) feed_byte(8'($urandom_range(0, 255)));
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                // Frame cut short: whatever follows is taken as the rest of its header.
                feed_byte(sof_cur);
                repeat ($urandom_range(1, 4)) feed_byte(8'($urandom_range(0, 255)));
            end else begin
                if (pick < 58) begin
                    len = 16'($urandom_range(0, 8));
                end else if (pick < 82) begin
                    len = 16'($urandom_range(9, 40));
                end else if (pick < 88) begin
                    len = 16'($urandom_range(41, crcfp_pkg::MAX_PAYLOAD - 1));
                end else if (pick < 89) begin
                    len = 16'(crcfp_pkg::MAX_PAYLOAD);
                end else if (pick < 92) begin
                    len = 16'(crcfp_pkg::MAX_PAYLOAD + 1);
                end else begin
                    len = 16'($urandom_range(crcfp_pkg::MAX_PAYLOAD + 2, 16'hFFFF));
                end
                send_frame(len, $urandom_range(0, 99) < 12);
            end
        end
    endtask

    initial begin
        dir_row_t    row;
        logic [7:0]  b;
        logic [7:0]  sof_plan [4];

        dir_rows = '{
            '{ROW_FEED,    8'h00, 8'h00, 1'b1, '{1'b0, 8'h00, 8'h00, 9'd0, 8'h00}},
            '{ROW_FEED,    8'hAA, 8'hFF, 1'b0, '0},
            '{ROW_FEED,    8'hFF, 8'h00, 1'b0, '0},
            '{ROW_FEED,    8'h00, 8'h00, 1'b0, '0},
            '{ROW_FEED,    8'h02, 8'h00, 1'b0, '0},
            '{ROW_FEED,    8'h00, 8'h00, 1'b0, '0},
            '{ROW_FEED,    8'h00, 8'h00, 1'b0, '0},
            '{ROW_FEED,    8'hFF, 8'h00, 1'b0, '0},
            '{ROW_CRC_HI,  8'h00, 8'h00, 1'b0, '0},
            '{ROW_CRC_LO,  8'h00, 8'h00, 1'b1, '{1'b1, 8'hFF, 8'h00, 9'd2, 8'h00}},
            '{ROW_READ,    8'h00, 8'h01, 1'b1, '{1'b0, 8'hFF, 8'h00, 9'd2, 8'hFF}},
            '{ROW_READ,    8'hFF, 8'h00, 1'b1, '{1'b0, 8'hFF, 8'h00, 9'd2, 8'h00}},
            // Zero-length frame goes straight to the CRC bytes; the CRC is then spoiled.
            '{ROW_FEED,    8'hAA, 8'h00, 1'b0, '0},
            '{ROW_FEED,    8'h80, 8'h00, 1'b0, '0},
            '{ROW_FEED,    8'h7F, 8'h00, 1'b0, '0},
            '{ROW_FEED,    8'h00, 8'h00, 1'b0, '0},
            '{ROW_FEED,    8'h00, 8'h00, 1'b0, '0},
            '{ROW_CRC_HI,  8'h00, 8'h00, 1'b0, '0},
            '{ROW_CRC_BAD, 8'h00, 8'h00, 1'b1, '{1'b0, 8'h80, 8'h7F, 9'd0, 8'h00}},
            // Oversized length drops the frame but keeps its sequence and command.
            '{ROW_FEED,    8'hAA, 8'h00, 1'b0, '0},
            '{ROW_FEED,    8'h11, 8'h00, 1'b0, '0},
            '{ROW_FEED,    8'h22, 8'h00, 1'b0, '0},
            '{ROW_FEED,    8'hFF, 8'h00, 1'b0, '0},
            '{ROW_FEED,    8'hFF, 8'h00, 1'b1, '{1'b0, 8'h11, 8'h22, 9'd0, 8'h00}},
            '{ROW_READ,    8'h55, 8'h01, 1'b1, '{1'b0, 8'h11, 8'h22, 9'd0, 8'hFF}}
        };

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            case (row.kind)
                ROW_CRC_HI:  b = crc_acc[15:8];
                ROW_CRC_LO:  b = crc_acc[7:0];
                ROW_CRC_BAD: b = crc_acc[7:0] ^ 8'h01;
                default:     b = row.data;
            endcase
            typed_res = row.res;
            typed_valid = row.typed;
            send_item((row.kind == ROW_READ) ? OP_READ : OP_FEED, b, row.index);
        end

        sof_plan[0] = 8'h00;
        sof_plan[1] = 8'hFF;
        sof_plan[2] = 8'($urandom_range(1, 254));
        sof_plan[3] = crcfp_pkg::SOF_RESET;
        for (int p = 0; p < 4; p++) begin
            // The sender holds off here until every expected result is back.
            wait_drained();
            write_sof(sof_plan[p]);
            calm = (p == 1);
            random_phase(PHASE_ITEMS, p == 0);
        end
        calm = 1'b0;

        wait_drained();
        repeat (10) @(negedge aclk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/crcfp_pkg.sv
design/crcfp_ram.sv
design/crcfp_parser.sv
design/crc16_frame_parser.sv
dv/crc16_frame_parser_tb.sv
